// File: rtl/bpfa_pkg.sv
// Shared types and constants for the bitmap page frame allocator.
// No dependencies; imported by the top level.
package bpfa_pkg;

    localparam int WORD_BITS        = 64;
    localparam int NUM_PAGES_DEF    = 4096;
    localparam int PAGE_BYTES_DEF   = 4096;
    localparam int RESV_W           = 13;
    localparam int PA_W             = 24;
    localparam logic [RESV_W-1:0] RESV_RST = 13'd256;

    typedef enum logic [1:0] {
        FN_INIT  = 2'd0,
        FN_ALLOC = 2'd1,
        FN_FREE  = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_MEM   = 2'd1,
        ST_BAD_SIZE = 2'd2
    } t_status;

endpackage

// File: rtl/bpfa_ram.sv
// Generic simple dual-port RAM with registered read.
// No dependencies; holds the used map of the allocator.
module bpfa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/bitmap_page_frame_allocator.sv
// Bitmap page frame allocator, next-fit scan over 64-bit map words (NW = NUM_PAGES/64 words, rounded up).
// An allocate scan reads one map word per cycle, and the map RAM read port sets that rate.
// One item at a time: no new request is taken until the last one has reached the output register.
// Reset is synchronous, active low, and starts a clearing pass over the map words;
// no item is taken until it ends. Depends on bpfa_pkg and bpfa_ram.
module bitmap_page_frame_allocator #(
    parameter int NUM_PAGES  = bpfa_pkg::NUM_PAGES_DEF,
    parameter int PAGE_BYTES = bpfa_pkg::PAGE_BYTES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [bpfa_pkg::RESV_W-1:0] i_cfg_data,       // reserved_pages
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [63:0]                 i_s_axis_tdata,   // request_size, address
    input  logic [1:0]                  i_s_axis_tuser,   // func
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [bpfa_pkg::PA_W-1:0]   o_m_axis_tdata,   // page_address
    output logic [1:0]                  o_m_axis_tuser    // status
);
    import bpfa_pkg::*;

    localparam int NW      = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW      = (NW > 1) ? $clog2(NW) : 1;
    localparam int HW      = $clog2(NUM_PAGES + 1);
    localparam int KW      = $clog2(NW + 2);
    localparam int BW      = $clog2(WORD_BITS);
    localparam int FRW     = AW + BW;
    localparam int PBS     = $clog2(PAGE_BYTES);
    localparam int NBYTE   = WORD_BITS / 8;
    localparam int SBW     = BW - 3;
    localparam int FULL_W  = NUM_PAGES / WORD_BITS;
    localparam int REM_W   = NUM_PAGES % WORD_BITS;
    localparam logic [WORD_BITS-1:0] REM_MASK = (WORD_BITS'(1) << REM_W) - WORD_BITS'(1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_INIT = 6'b000010,
        S_SCAN = 6'b000100,
        S_MARK = 6'b001000,
        S_FREE = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state                r_state, n_state;
    logic                  r_quiet, n_quiet;
    logic [HW-1:0]         r_hint, n_hint;
    logic [RESV_W-1:0]     r_resv, n_resv;
    logic [HW-1:0]         r_fill, n_fill;
    logic [AW-1:0]         r_waddr, n_waddr;
    logic [BW-1:0]         r_bit, n_bit;
    logic [WORD_BITS-1:0]  r_word, n_word;
    logic [AW-1:0]         r_rd_addr, n_rd_addr;
    logic [KW-1:0]         r_rd_k, n_rd_k;
    logic [SBW-1:0]        r_sb, n_sb;
    logic                  r_chk_valid, n_chk_valid;
    logic                  r_chk_first, n_chk_first;
    logic                  r_chk_last, n_chk_last;
    logic [AW-1:0]         r_chk_addr, n_chk_addr;
    t_status               r_st, n_st;
    logic [PA_W-1:0]       r_pa, n_pa;
    logic                  r_out_valid, n_out_valid;
    t_status               r_out_st, n_out_st;
    logic [PA_W-1:0]       r_out_pa, n_out_pa;

    logic                  ram_we, ram_re;
    logic [AW-1:0]         ram_waddr, ram_raddr;
    logic [WORD_BITS-1:0]  ram_wdata, ram_rdata;

    logic                  in_xfer;
    logic [31:0]           in_size, in_addr, free_frame, hint32, sw32, left32, resv_sat;
    logic                  free_ok;
    logic [WORD_BITS-1:0]  real_mask, byte_mask, free_bits, fill_word;
    logic                  found;
    logic [BW-1:0]         found_bit;
    logic [FRW-1:0]        frame;
    logic [FRW+PBS-1:0]    byte_addr;

    bpfa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NW),
        .AW    (AW)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;
    assign in_size         = i_s_axis_tdata[31:0];
    assign in_addr         = i_s_axis_tdata[63:32];
    assign free_frame      = in_addr >> PBS;
    assign free_ok         = (in_addr != 32'd0) && (free_frame < NUM_PAGES);
    assign hint32          = 32'(r_hint);
    assign sw32            = hint32 >> BW;
    assign left32          = 32'(r_fill);
    assign resv_sat        = (32'(r_resv) > NUM_PAGES) ? NUM_PAGES : 32'(r_resv);
    assign fill_word       = (left32 >= WORD_BITS) ? '1 :
                             ((WORD_BITS'(1) << r_fill[BW-1:0]) - WORD_BITS'(1));
    assign frame           = {r_waddr, r_bit};
    assign byte_addr       = (FRW + PBS)'(frame) << PBS;

    // Mask off frames past the end and bytes outside this pass of the wrap.
    always_comb begin
        if (32'(r_chk_addr) < FULL_W) begin
            real_mask = '1;
        end else if (32'(r_chk_addr) == FULL_W) begin
            real_mask = REM_MASK;
        end else begin
            real_mask = '0;
        end
        for (int j = 0; j < NBYTE; j++) begin
            if (r_chk_first) begin
                byte_mask[j*8 +: 8] = {8{SBW'(j) >= r_sb}};
            end else if (r_chk_last) begin
                byte_mask[j*8 +: 8] = {8{SBW'(j) < r_sb}};
            end else begin
                byte_mask[j*8 +: 8] = 8'hFF;
            end
        end
        free_bits = ~ram_rdata & real_mask & byte_mask;
        found     = 1'b0;
        found_bit = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (free_bits[i]) begin
                found     = 1'b1;
                found_bit = BW'(i);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_quiet     = r_quiet;
        n_hint      = r_hint;
        n_resv      = (i_cfg_valid && o_cfg_ready) ? i_cfg_data : r_resv;
        n_fill      = r_fill;
        n_waddr     = r_waddr;
        n_bit       = r_bit;
        n_word      = r_word;
        n_rd_addr   = r_rd_addr;
        n_rd_k      = r_rd_k;
        n_sb        = r_sb;
        n_chk_valid = 1'b0;
        n_chk_first = r_chk_first;
        n_chk_last  = r_chk_last;
        n_chk_addr  = r_chk_addr;
        n_st        = r_st;
        n_pa        = r_pa;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_st    = r_out_st;
        n_out_pa    = r_out_pa;
        ram_we      = 1'b0;
        ram_waddr   = r_waddr;
        ram_wdata   = fill_word;
        ram_re      = 1'b0;
        ram_raddr   = r_rd_addr;

        unique case (r_state)
            S_IDLE: begin
                n_st = ST_OK;
                n_pa = '0;
                if (in_xfer) begin
                    unique case (t_func'(i_s_axis_tuser))
                        FN_INIT: begin
                            n_fill  = HW'(resv_sat);
                            n_hint  = HW'(resv_sat);
                            n_waddr = '0;
                            n_state = S_INIT;
                        end
                        FN_ALLOC: begin
                            if (in_size != PAGE_BYTES) begin
                                n_st    = ST_BAD_SIZE;
                                n_state = S_DONE;
                            end else begin
                                if (sw32 >= NW) begin
                                    n_rd_addr = '0;
                                    n_sb      = '0;
                                end else begin
                                    n_rd_addr = AW'(sw32);
                                    n_sb      = hint32[BW-1:3];
                                end
                                n_rd_k  = '0;
                                n_state = S_SCAN;
                            end
                        end
                        FN_FREE: begin
                            if (free_ok) begin
                                ram_re    = 1'b1;
                                ram_raddr = AW'(free_frame >> BW);
                                n_waddr   = AW'(free_frame >> BW);
                                n_bit     = free_frame[BW-1:0];
                                if (free_frame < hint32) begin
                                    n_hint = HW'(free_frame);
                                end
                                n_state = S_FREE;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_INIT: begin
                ram_we    = 1'b1;
                ram_waddr = r_waddr;
                ram_wdata = fill_word;
                n_fill    = (left32 >= WORD_BITS) ? HW'(left32 - WORD_BITS) : '0;
                n_waddr   = r_waddr + AW'(1);
                if (r_waddr == AW'(NW - 1)) begin
                    n_state = r_quiet ? S_IDLE : S_DONE;
                    n_quiet = 1'b0;
                end
            end
            S_SCAN: begin
                if (32'(r_rd_k) <= NW) begin
                    ram_re      = 1'b1;
                    ram_raddr   = r_rd_addr;
                    n_rd_addr   = (r_rd_addr == AW'(NW - 1)) ? '0 : r_rd_addr + AW'(1);
                    n_rd_k      = r_rd_k + KW'(1);
                    n_chk_valid = 1'b1;
                    n_chk_first = (r_rd_k == '0);
                    n_chk_last  = (32'(r_rd_k) == NW);
                    n_chk_addr  = r_rd_addr;
                end
                if (r_chk_valid) begin
                    if (found) begin
                        n_waddr     = r_chk_addr;
                        n_bit       = found_bit;
                        n_word      = ram_rdata;
                        n_chk_valid = 1'b0;
                        n_state     = S_MARK;
                    end else if (r_chk_last) begin
                        n_st        = ST_NO_MEM;
                        n_chk_valid = 1'b0;
                        n_state     = S_DONE;
                    end
                end
            end
            S_MARK: begin
                ram_we    = 1'b1;
                ram_waddr = r_waddr;
                ram_wdata = r_word | (WORD_BITS'(1) << r_bit);
                n_hint    = HW'(32'(frame) + 32'd1);
                n_pa      = PA_W'(byte_addr);
                n_state   = S_DONE;
            end
            S_FREE: begin
                ram_we    = 1'b1;
                ram_waddr = r_waddr;
                ram_wdata = ram_rdata & ~(WORD_BITS'(1) << r_bit);
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_st    = r_st;
                    n_out_pa    = r_pa;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_quiet     <= 1'b1;
            r_hint      <= '0;
            r_resv      <= RESV_RST;
            r_fill      <= '0;
            r_waddr     <= '0;
            r_chk_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_quiet     <= n_quiet;
            r_hint      <= n_hint;
            r_resv      <= n_resv;
            r_fill      <= n_fill;
            r_waddr     <= n_waddr;
            r_chk_valid <= n_chk_valid;
            r_out_valid <= n_out_valid;
        end
        r_bit       <= n_bit;
        r_word      <= n_word;
        r_rd_addr   <= n_rd_addr;
        r_rd_k      <= n_rd_k;
        r_sb        <= n_sb;
        r_chk_first <= n_chk_first;
        r_chk_last  <= n_chk_last;
        r_chk_addr  <= n_chk_addr;
        r_st        <= n_st;
        r_pa        <= n_pa;
        r_out_st    <= n_out_st;
        r_out_pa    <= n_out_pa;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_st;
    assign o_m_axis_tdata  = r_out_pa;

`ifndef SYNTH
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input taken while an operation is in progress");

    a_addr_only_on_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser != ST_OK)) |-> (o_m_axis_tdata == '0))
        else $error("page address set on a failed operation");

    a_hint_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_hint) <= NUM_PAGES)
        else $error("search hint beyond the last frame");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (32'(r_rd_k) <= NW + 1))
        else $error("map scan ran past one full wrap");
`endif

endmodule
